// ===== design/dmdr_pkg.sv =====
// Shared types, widths and codes for the dual motor duty ramp.
// Used by the lane, control, skid and top modules and the testbench; depends on nothing.
package dmdr_pkg;

	localparam int DUTY_W    = 16;
	localparam int MAG_W     = 15;
	localparam int LIMIT_W   = 15;
	localparam int NUM_LANES = 2;
	localparam int LANE_UP   = 0;
	localparam int LANE_DOWN = 1;

	// Configuration port geometry and register map.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_UP_LIMIT   = 2'd0;
	localparam logic [1:0] REG_DOWN_LIMIT = 2'd1;
	localparam logic [1:0] REG_STEP_SIZE  = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'h7FFF;
	localparam logic [LIMIT_W-1:0] STEP_RST  = 15'd10;

	// Command codes carried by a request.
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_SET   = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_e_t;

	// Phase codes as they appear in a result.
	localparam logic [1:0] PHASE_IDLE    = 2'd0;
	localparam logic [1:0] PHASE_RAMPING = 2'd1;
	localparam logic [1:0] PHASE_READY   = 2'd2;

	// Lane update strobes from the control stage, shared by both lanes.
	typedef struct packed {
		logic clear;
		logic load;
		logic step;
	} lane_ctl_t;

	// What one lane reports after the request.
	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             reverse;
		logic             done;
	} lane_res_t;

	// Shared control state.
	typedef struct packed {
		logic [1:0] phase;
		logic       enabled;
	} ctrl_state_t;

	// One result item.
	typedef struct packed {
		logic [MAG_W-1:0] up_magnitude;
		logic             up_reverse;
		logic [MAG_W-1:0] down_magnitude;
		logic             down_reverse;
		logic             drive_enabled;
		logic [1:0]       phase;
	} res_t;

	// Clamp a signed value to plus or minus a limit.
	function automatic logic signed [DUTY_W-1:0] clamp_duty(
		input logic signed [DUTY_W:0] v,
		input logic [LIMIT_W-1:0]     lim
	);
		logic signed [DUTY_W:0] m;
		logic signed [DUTY_W:0] r;
		m = signed'({2'b00, lim});
		priority if (v > m) begin
			r = m;
		end else if (v < -m) begin
			r = -m;
		end else begin
			r = v;
		end
		return r[DUTY_W-1:0];
	endfunction

endpackage

// ===== design/dmdr_in_if.sv =====
// Request channel of the dual motor duty ramp.
// Depends on nothing; the payload widths match dmdr_pkg.
interface dmdr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] up_request;
	logic signed [15:0] down_request;

	modport source (output valid, output command, output up_request,
		output down_request, input ready);
	modport sink (input valid, input command, input up_request,
		input down_request, output ready);
endinterface

// ===== design/dmdr_out_if.sv =====
// Result channel of the dual motor duty ramp.
// Depends on nothing; the payload widths match dmdr_pkg.
interface dmdr_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] up_magnitude;
	logic        up_reverse;
	logic [14:0] down_magnitude;
	logic        down_reverse;
	logic        drive_enabled;
	logic [1:0]  phase;

	modport source (output valid, output up_magnitude, output up_reverse,
		output down_magnitude, output down_reverse, output drive_enabled,
		output phase, input ready);
	modport sink (input valid, input up_magnitude, input up_reverse,
		input down_magnitude, input down_reverse, input drive_enabled,
		input phase, output ready);
endinterface

// ===== design/dmdr_lane.sv =====
// One motor ramp lane: goal, level and direction registers with the step logic.
// Depends on dmdr_pkg.
module dmdr_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmdr_pkg::lane_ctl_t                 ctl,
	input  logic signed [dmdr_pkg::DUTY_W-1:0]  request,
	input  logic [dmdr_pkg::LIMIT_W-1:0]        limit,
	input  logic [dmdr_pkg::LIMIT_W-1:0]        step_size,
	output dmdr_pkg::lane_res_t                 res
);
	import dmdr_pkg::*;

	logic signed [DUTY_W-1:0] level_q;
	logic signed [DUTY_W-1:0] goal_q;
	logic                     dir_q;
	logic signed [DUTY_W-1:0] level_d;
	logic signed [DUTY_W-1:0] goal_d;
	logic                     dir_d;
	logic signed [DUTY_W-1:0] target;
	logic signed [DUTY_W-1:0] stepped;
	logic signed [DUTY_W+1:0] lvl_x;
	logic signed [DUTY_W+1:0] tgt_x;
	logic signed [DUTY_W+1:0] stp_x;
	logic signed [DUTY_W+1:0] up_x;
	logic signed [DUTY_W+1:0] dn_x;
	logic [DUTY_W-1:0]        abs_lvl;

	// Goal clamped against the present limit, then one move toward it.
	always_comb begin
		target = clamp_duty({goal_q[DUTY_W-1], goal_q}, limit);
		lvl_x  = {{2{level_q[DUTY_W-1]}}, level_q};
		tgt_x  = {{2{target[DUTY_W-1]}}, target};
		stp_x  = signed'({3'b000, step_size});
		up_x   = lvl_x + stp_x;
		dn_x   = lvl_x - stp_x;
		priority if (tgt_x > up_x) begin
			stepped = up_x[DUTY_W-1:0];
		end else if (tgt_x < dn_x) begin
			stepped = dn_x[DUTY_W-1:0];
		end else begin
			stepped = target;
		end
	end

	// Next state for the request in hand.
	always_comb begin
		level_d = level_q;
		goal_d  = goal_q;
		dir_d   = dir_q;
		if (ctl.clear) begin
			level_d = '0;
			goal_d  = '0;
		end else if (ctl.load) begin
			goal_d = clamp_duty({request[DUTY_W-1], request}, limit);
		end else if (ctl.step) begin
			level_d = stepped;
			if (stepped > 0) begin
				dir_d = 1'b0;
			end else if (stepped < 0) begin
				dir_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			goal_q  <= '0;
			dir_q   <= 1'b0;
		end else begin
			level_q <= level_d;
			goal_q  <= goal_d;
			dir_q   <= dir_d;
		end
	end

	// The level never reaches the most negative code, so its magnitude fits.
	assign abs_lvl       = level_d[DUTY_W-1] ? 16'(-level_d) : 16'(level_d);
	assign res.magnitude = abs_lvl[MAG_W-1:0];
	assign res.reverse   = dir_d;
	assign res.done      = (stepped == target);
endmodule

// ===== design/dmdr_ctrl.sv =====
// Shared phase and enable control; merges the lane results into the phase.
// Depends on dmdr_pkg.
module dmdr_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic [1:0]                             command,
	input  logic [dmdr_pkg::NUM_LANES-1:0]         lane_done,
	output dmdr_pkg::lane_ctl_t                    ctl,
	output dmdr_pkg::ctrl_state_t                  cur,
	output dmdr_pkg::ctrl_state_t                  nxt
);
	import dmdr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE    = PHASE_IDLE,
		ST_RAMPING = PHASE_RAMPING,
		ST_READY   = PHASE_READY
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   enabled_q;
	logic   enabled_d;
	cmd_e_t cmd;

	assign cmd = cmd_e_t'(command);

	// Decode the request into lane strobes, the next phase and the next enable.
	always_comb begin
		state_d   = state_q;
		enabled_d = enabled_q;
		ctl       = '0;
		if (accept) begin
			unique case (cmd)
				CMD_START: begin
					enabled_d = 1'b1;
					state_d   = ST_IDLE;
					ctl.clear = 1'b1;
				end
				CMD_STOP: begin
					enabled_d = 1'b0;
					state_d   = ST_IDLE;
					ctl.clear = 1'b1;
				end
				CMD_SET: begin
					state_d  = ST_RAMPING;
					ctl.load = 1'b1;
				end
				CMD_TICK: begin
					if (state_q == ST_RAMPING) begin
						ctl.step = 1'b1;
						if (&lane_done) begin
							state_d = ST_READY;
						end
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enabled_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			enabled_q <= enabled_d;
		end
	end

	assign cur.phase   = state_q;
	assign cur.enabled = enabled_q;
	assign nxt.phase   = state_d;
	assign nxt.enabled = enabled_d;
endmodule

// ===== design/dmdr_skid.sv =====
// Output register with a skid stage so one more request can be taken under a stall.
// Depends on dmdr_pkg.
module dmdr_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dmdr_pkg::res_t  push_data,
	output logic            can_push,
	output logic            out_valid,
	output dmdr_pkg::res_t  out_data,
	input  logic            out_ready
);
	import dmdr_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop      = out_valid_q && out_ready;
	assign can_push = !skid_valid_q;

	// Occupancy of the two entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q;
			end
		end
	end

	// Payload moves: the skid entry drains first, a new result fills behind.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== design/dual_motor_duty_ramp.sv =====
// Top level of the dual motor duty ramp: two ramp lanes, control, output skid
// and the register port. Depends on dmdr_pkg, the channel interfaces and submodules.
//
//   channel   dir   handshake           payload
//   cmd_ch    in    valid / ready       command, up_request, down_request
//   res_ch    out   valid / ready       magnitudes, directions, drive_enabled, phase
//   APB       in    psel/penable/pready up_limit, down_limit, step_size
//
// One request per cycle while cmd_ch.ready is high; each request yields one result.
// The lanes update in the cycle of acceptance; the output register plus skid entry
// hold two results, so cmd_ch.ready drops only when both are full.
// Reset clears levels, goals, directions, phase and enable; limits reset to full
// scale and the step size to ten.
module dual_motor_duty_ramp (
	input  logic                          clk,
	input  logic                          arst_n,
	dmdr_in_if.sink                       cmd_ch,
	dmdr_out_if.source                    res_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dmdr_pkg::APB_AW-1:0]   paddr,
	input  logic [dmdr_pkg::APB_DW-1:0]   pwdata,
	output logic [dmdr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import dmdr_pkg::*;

	logic [LIMIT_W-1:0]        up_limit_q;
	logic [LIMIT_W-1:0]        down_limit_q;
	logic [LIMIT_W-1:0]        step_size_q;
	logic [1:0]                reg_idx;
	logic                      wr_en;
	logic                      accept;
	logic                      can_push;
	lane_ctl_t                 ctl;
	ctrl_state_t               cur;
	ctrl_state_t               nxt;
	lane_res_t                 lane_res [NUM_LANES];
	logic [NUM_LANES-1:0]      lane_done;
	logic signed [DUTY_W-1:0]  lane_req [NUM_LANES];
	logic [LIMIT_W-1:0]        lane_lim [NUM_LANES];
	res_t                      res_d;
	res_t                      res_q;
	logic                      res_valid;

	// Configuration registers.
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_limit_q   <= LIMIT_RST;
			down_limit_q <= LIMIT_RST;
			step_size_q  <= STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_UP_LIMIT:   up_limit_q   <= pwdata[LIMIT_W-1:0];
				REG_DOWN_LIMIT: down_limit_q <= pwdata[LIMIT_W-1:0];
				REG_STEP_SIZE:  step_size_q  <= pwdata[LIMIT_W-1:0];
				default:        up_limit_q   <= up_limit_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_UP_LIMIT:   prdata = APB_DW'(up_limit_q);
			REG_DOWN_LIMIT: prdata = APB_DW'(down_limit_q);
			REG_STEP_SIZE:  prdata = APB_DW'(step_size_q);
			default:        prdata = '0;
		endcase
	end

	// Request handshake.
	assign accept       = cmd_ch.valid && can_push;
	assign cmd_ch.ready = can_push;

	// Ramp lanes, one per motor.
	assign lane_req[LANE_UP]   = cmd_ch.up_request;
	assign lane_req[LANE_DOWN] = cmd_ch.down_request;
	assign lane_lim[LANE_UP]   = up_limit_q;
	assign lane_lim[LANE_DOWN] = down_limit_q;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		dmdr_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.request   (lane_req[i]),
			.limit     (lane_lim[i]),
			.step_size (step_size_q),
			.res       (lane_res[i])
		);
		assign lane_done[i] = lane_res[i].done;
	end

	dmdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (cmd_ch.command),
		.lane_done (lane_done),
		.ctl       (ctl),
		.cur       (cur),
		.nxt       (nxt)
	);

	// Result assembly and output buffering.
	always_comb begin
		res_d.up_magnitude   = lane_res[LANE_UP].magnitude;
		res_d.up_reverse     = lane_res[LANE_UP].reverse;
		res_d.down_magnitude = lane_res[LANE_DOWN].magnitude;
		res_d.down_reverse   = lane_res[LANE_DOWN].reverse;
		res_d.drive_enabled  = nxt.enabled;
		res_d.phase          = nxt.phase;
	end

	dmdr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_d),
		.can_push  (can_push),
		.out_valid (res_valid),
		.out_data  (res_q),
		.out_ready (res_ch.ready)
	);

	assign res_ch.valid          = res_valid;
	assign res_ch.up_magnitude   = res_q.up_magnitude;
	assign res_ch.up_reverse     = res_q.up_reverse;
	assign res_ch.down_magnitude = res_q.down_magnitude;
	assign res_ch.down_reverse   = res_q.down_reverse;
	assign res_ch.drive_enabled  = res_q.drive_enabled;
	assign res_ch.phase          = res_q.phase;

`ifndef NO_ASSERTIONS
	// Back-pressure only when a result is already waiting at the output.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ch.ready |-> res_ch.valid)
		else $error("request side stalled with no result waiting");

	// A stop always leaves the drive disabled.
	a_stop_disables: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_ch.command == CMD_STOP) |=> !cur.enabled)
		else $error("drive still enabled after stop");

	// A tick does nothing while idle.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_ch.command == CMD_TICK && cur.phase == PHASE_IDLE)
		|=> cur.phase == PHASE_IDLE)
		else $error("tick left the idle phase");
`endif
endmodule

// ===== tb/dual_motor_duty_ramp_tb.sv =====
// Self-checking testbench for the dual motor duty ramp: directed and random requests,
// an in-bench ramp predictor and an in-order result checker.
// Depends on dmdr_pkg, the request and result channel interfaces and the RTL top.
`timescale 1ns / 100ps

module dual_motor_duty_ramp_tb;
	import dmdr_pkg::*;

	localparam int         CYCLE_LIMIT    = 400000;
	localparam int         DRAIN_CYCLES   = 4;
	localparam int         MAX_RAMP_TICKS = 40;
	localparam logic [1:0] REG_UNUSED     = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	dmdr_in_if  cmd_if ();
	dmdr_out_if res_if ();

	dual_motor_duty_ramp i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_if),
		.res_ch  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted ramp state and register copies.
	int         lane_level [NUM_LANES];
	int         lane_goal  [NUM_LANES];
	logic       lane_rev   [NUM_LANES];
	int         lane_limit [NUM_LANES];
	int         model_step;
	logic [1:0] model_phase;
	logic       drive_on;

	res_t expected_results [$];

	int send_idle_pct;
	int recv_stall_pct;
	int request_span;
	int requests_sent;
	int results_checked;
	int ready_results;
	int reg_writes;
	int mismatch_count;
	int cycle_count;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result receiver with random back-pressure.
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int clamp_duty_to(int v, int lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	// Move one lane toward its goal, clamped against the present limit.
	function automatic bit advance_lane(int lane);
		int target;
		int lvl;
		target = clamp_duty_to(lane_goal[lane], lane_limit[lane]);
		lvl = lane_level[lane];
		if (target > lvl + model_step) begin
			lvl = lvl + model_step;
		end else if (target < lvl - model_step) begin
			lvl = lvl - model_step;
		end else begin
			lvl = target;
		end
		lane_level[lane] = lvl;
		// The direction holds its last value while the level is zero.
		if (lvl > 0) begin
			lane_rev[lane] = 1'b0;
		end else if (lvl < 0) begin
			lane_rev[lane] = 1'b1;
		end
		return lvl == target;
	endfunction

	// Apply one accepted request to the predicted state and return its result.
	function automatic res_t predict_ramp_result(cmd_e_t c, logic signed [15:0] up_req,
		logic signed [15:0] down_req);
		bit   up_settled;
		bit   down_settled;
		int   up_abs;
		int   down_abs;
		res_t r;
		case (c)
			CMD_START, CMD_STOP: begin
				drive_on = (c == CMD_START);
				for (int i = 0; i < NUM_LANES; i++) begin
					lane_level[i] = 0;
					lane_goal[i] = 0;
				end
				model_phase = PHASE_IDLE;
			end
			CMD_SET: begin
				lane_goal[LANE_UP] = clamp_duty_to(int'(up_req), lane_limit[LANE_UP]);
				lane_goal[LANE_DOWN] = clamp_duty_to(int'(down_req), lane_limit[LANE_DOWN]);
				model_phase = PHASE_RAMPING;
			end
			default: begin
				if (model_phase == PHASE_RAMPING) begin
					up_settled = advance_lane(LANE_UP);
					down_settled = advance_lane(LANE_DOWN);
					if (up_settled && down_settled) begin
						model_phase = PHASE_READY;
					end
				end
			end
		endcase
		up_abs = (lane_level[LANE_UP] < 0) ? -lane_level[LANE_UP] : lane_level[LANE_UP];
		down_abs = (lane_level[LANE_DOWN] < 0) ? -lane_level[LANE_DOWN]
			: lane_level[LANE_DOWN];
		r.up_magnitude = up_abs[MAG_W-1:0];
		r.up_reverse = lane_rev[LANE_UP];
		r.down_magnitude = down_abs[MAG_W-1:0];
		r.down_reverse = lane_rev[LANE_DOWN];
		r.drive_enabled = drive_on;
		r.phase = model_phase;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_checked, what,
			got, want);
		mismatch_count++;
	endtask

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (res_if.up_magnitude !== want.up_magnitude)
					report_mismatch("up_magnitude", res_if.up_magnitude, want.up_magnitude);
				if (res_if.up_reverse !== want.up_reverse)
					report_mismatch("up_reverse", res_if.up_reverse, want.up_reverse);
				if (res_if.down_magnitude !== want.down_magnitude)
					report_mismatch("down_magnitude", res_if.down_magnitude,
						want.down_magnitude);
				if (res_if.down_reverse !== want.down_reverse)
					report_mismatch("down_reverse", res_if.down_reverse, want.down_reverse);
				if (res_if.drive_enabled !== want.drive_enabled)
					report_mismatch("drive_enabled", res_if.drive_enabled,
						want.drive_enabled);
				if (res_if.phase !== want.phase)
					report_mismatch("phase", res_if.phase, want.phase);
				if (want.phase == PHASE_READY)
					ready_results++;
				results_checked++;
			end
		end
	end

	// Send one request, with random idle cycles ahead of it, and predict its result.
	task automatic send_request(cmd_e_t c, logic [15:0] up_req, logic [15:0] down_req);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= c;
		cmd_if.up_request <= up_req;
		cmd_if.down_request <= down_req;
		do begin
			@(posedge clk);
		end while (!cmd_if.ready);
		expected_results.push_back(predict_ramp_result(c, up_req, down_req));
		requests_sent++;
	endtask

	// Stop sending and let every pending result arrive.
	task automatic wait_for_results();
		cmd_if.valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(logic [1:0] idx, output logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register once the block is idle and track it in the predictor.
	task automatic set_register(logic [1:0] idx, logic [LIMIT_W-1:0] value);
		wait_for_results();
		apb_write(idx, {{(APB_DW-LIMIT_W){1'b0}}, value});
		case (idx)
			REG_UP_LIMIT:   lane_limit[LANE_UP] = int'(value);
			REG_DOWN_LIMIT: lane_limit[LANE_DOWN] = int'(value);
			REG_STEP_SIZE:  model_step = int'(value);
			default: ;
		endcase
		reg_writes++;
	endtask

	// Read back all three registers against the tracked values.
	task automatic check_registers();
		logic [APB_DW-1:0] data;
		apb_read(REG_UP_LIMIT, data);
		if (data !== APB_DW'(lane_limit[LANE_UP]))
			report_mismatch("up_limit readback", data, lane_limit[LANE_UP]);
		apb_read(REG_DOWN_LIMIT, data);
		if (data !== APB_DW'(lane_limit[LANE_DOWN]))
			report_mismatch("down_limit readback", data, lane_limit[LANE_DOWN]);
		apb_read(REG_STEP_SIZE, data);
		if (data !== APB_DW'(model_step))
			report_mismatch("step_size readback", data, model_step);
	endtask

	// Tick while the prediction says the ramp is still moving, then a few more.
	task automatic tick_until_ready(int extra);
		int guard = 0;
		while (model_phase == PHASE_RAMPING && guard < MAX_RAMP_TICKS) begin
			send_request(CMD_TICK, 16'($urandom), 16'($urandom));
			guard++;
		end
		repeat (extra) send_request(CMD_TICK, 16'($urandom), 16'($urandom));
	endtask

	// Random duty request: small around zero for slow ramps, else full scale.
	function automatic logic [15:0] pick_request();
		int v;
		if (request_span > 0) begin
			v = $urandom_range(0, 2 * request_span) - request_span;
			return v[15:0];
		end
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Reset values, a tick in idle, then stop and start.
	task automatic test_reset_state();
		check_registers();
		send_request(CMD_TICK, 16'h7FFF, 16'h8000);
		send_request(CMD_STOP, 16'h0000, 16'hFFFF);
		send_request(CMD_START, 16'hFFFF, 16'h0000);
	endtask

	// Ramp with the reset step, a tick once ready, and direction hold after stop.
	task automatic test_basic_ramp();
		send_request(CMD_SET, 16'd25, -16'sd25);
		tick_until_ready(1);
		send_request(CMD_STOP, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
	endtask

	// Full-scale requests, the most negative one, and a return to zero.
	task automatic test_full_scale();
		set_register(REG_STEP_SIZE, 15'h7FFF);
		send_request(CMD_START, 16'h0000, 16'h0000);
		send_request(CMD_SET, 16'h7FFF, 16'h8000);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
		send_request(CMD_SET, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
	endtask

	// Limits lowered in the middle of a ramp clamp the stored goals on later ticks.
	task automatic test_limit_change();
		set_register(REG_STEP_SIZE, 15'd300);
		send_request(CMD_SET, 16'd1000, -16'sd1000);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
		set_register(REG_UP_LIMIT, 15'd100);
		set_register(REG_DOWN_LIMIT, 15'd0);
		tick_until_ready(0);
	endtask

	// A zero step never moves the level; set target while disabled still ramps.
	task automatic test_zero_step();
		set_register(REG_STEP_SIZE, 15'd0);
		send_request(CMD_SET, 16'd5, -16'sd5);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
		send_request(CMD_STOP, 16'h0000, 16'h0000);
		send_request(CMD_SET, 16'd7, 16'd7);
		set_register(REG_UP_LIMIT, LIMIT_RST);
		set_register(REG_DOWN_LIMIT, LIMIT_RST);
		set_register(REG_STEP_SIZE, STEP_RST);
		send_request(CMD_TICK, 16'h0000, 16'h0000);
	endtask

	// A write to the unused address leaves every register as it was.
	task automatic test_unknown_register();
		set_register(REG_UNUSED, 15'h1234);
		check_registers();
	endtask

	// Pick new register values, extremes included, while the block is idle.
	task automatic choose_random_setting();
		logic [LIMIT_W-1:0] up_lim;
		logic [LIMIT_W-1:0] down_lim;
		logic [LIMIT_W-1:0] step_val;
		up_lim = ($urandom_range(3) == 0) ? LIMIT_RST : LIMIT_W'($urandom_range(32767));
		down_lim = ($urandom_range(3) == 0) ? LIMIT_RST : LIMIT_W'($urandom_range(32767));
		case ($urandom_range(7))
			0: begin
				up_lim = LIMIT_RST;
				down_lim = LIMIT_RST;
				step_val = 15'h7FFF;
			end
			1: begin
				up_lim = '0;
				down_lim = '0;
				step_val = LIMIT_W'($urandom_range(1, 32767));
			end
			2, 3: step_val = LIMIT_W'($urandom_range(1000, 32767));
			4: step_val = LIMIT_W'($urandom_range(1, 20));
			5: step_val = '0;
			default: step_val = LIMIT_W'($urandom_range(1, 32767));
		endcase
		request_span = (step_val < 1000) ? 8 * int'(step_val) + 20 : 0;
		set_register(REG_UP_LIMIT, up_lim);
		set_register(REG_DOWN_LIMIT, down_lim);
		set_register(REG_STEP_SIZE, step_val);
	endtask

	// Random traffic: mostly full ramps, some noise and some interrupted ramps.
	task automatic run_random_phase(int idle_pct, int stall_pct, int items);
		int first;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < 4; s++) begin
			choose_random_setting();
			first = requests_sent;
			while (requests_sent - first < items / 4) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
						if ($urandom_range(3) == 0)
							send_request(CMD_START, 16'($urandom), 16'($urandom));
						send_request(CMD_SET, pick_request(), pick_request());
						tick_until_ready($urandom_range(2));
					end
					14, 15, 16: begin
						send_request(cmd_e_t'($urandom_range(3)), 16'($urandom),
							16'($urandom));
					end
					default: begin
						send_request(CMD_SET, pick_request(), pick_request());
						repeat ($urandom_range(1, 3))
							send_request(CMD_TICK, 16'($urandom), 16'($urandom));
						send_request(($urandom_range(1) == 0) ? CMD_STOP : CMD_START,
							16'($urandom), 16'($urandom));
					end
				endcase
			end
		end
	endtask

	initial begin
		// Known values on every input, and the predictor at its reset state.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.command = CMD_TICK;
		cmd_if.up_request = '0;
		cmd_if.down_request = '0;
		res_if.ready = 1'b0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		request_span = 0;
		requests_sent = 0;
		results_checked = 0;
		ready_results = 0;
		reg_writes = 0;
		mismatch_count = 0;
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_level[i] = 0;
			lane_goal[i] = 0;
			lane_rev[i] = 1'b0;
			lane_limit[i] = int'(LIMIT_RST);
		end
		model_step = int'(STEP_RST);
		model_phase = PHASE_IDLE;
		drive_on = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_basic_ramp();
		test_full_scale();
		test_limit_change();
		test_zero_step();
		test_unknown_register();

		run_random_phase(0, 0, 80);
		run_random_phase(66, 0, 80);
		run_random_phase(0, 66, 80);
		run_random_phase(17, 17, 80);
		wait_for_results();

		$display("Sent %0d requests and checked %0d results, %0d of them in READY.",
			requests_sent, results_checked, ready_results);
		$display("Made %0d register writes across idle, stalled and mixed traffic.",
			reg_writes);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/dmdr_pkg.sv
design/dmdr_in_if.sv
design/dmdr_out_if.sv
design/dmdr_lane.sv
design/dmdr_ctrl.sv
design/dmdr_skid.sv
design/dual_motor_duty_ramp.sv
tb/dual_motor_duty_ramp_tb.sv
